// ----- design/gfau_pkg.sv -----
// ----------------------------------------------------------------------------
// gfau_pkg
// Shared widths, operation codes, payload and control types and the field
// helper functions of the GF(2^m) arithmetic unit.
// ----------------------------------------------------------------------------
package gfau_pkg;

  localparam int unsigned FIELD_BITS = 8;
  localparam int unsigned EXP_BITS   = 16;
  localparam int unsigned MOD_W      = FIELD_BITS + 1;
  localparam int unsigned DEG_W      = $clog2(FIELD_BITS + 1);
  localparam int unsigned CNT_W      = $clog2(EXP_BITS + 1);

  localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(9'h11B);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_POW = 2'd2;
  localparam logic [1:0] OP_INV = 2'd3;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [FIELD_BITS-1:0] operand_a;
    logic [FIELD_BITS-1:0] operand_b;
    logic [EXP_BITS-1:0]   exponent;
  } req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] result;
    logic                  zero_inverse_error;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic pow_step;
    logic inv_step;
    logic finish;
    logic finish_inv;
  } dp_cmd_t;

  typedef struct packed {
    logic inv_done;
  } dp_sts_t;

  // carry-less product reduced by a monic modulus
  function automatic logic [FIELD_BITS-1:0] gf_mul(input logic [FIELD_BITS-1:0] a,
                                                   input logic [FIELD_BITS-1:0] b,
                                                   input logic [MOD_W-1:0]      m);
    logic [2*FIELD_BITS-1:0] p;
    p = '0;
    for (int i = 0; i < FIELD_BITS; i++) begin
      if (a[i]) begin
        p = p ^ ({{FIELD_BITS{1'b0}}, b} << i);
      end
    end
    for (int i = 2 * FIELD_BITS - 2; i >= FIELD_BITS; i--) begin
      if (p[i]) begin
        p = p ^ ({{(FIELD_BITS-1){1'b0}}, m} << (i - FIELD_BITS));
      end
    end
    return p[FIELD_BITS-1:0];
  endfunction

  // position of the leading one, zero for zero
  function automatic logic [DEG_W-1:0] poly_deg(input logic [MOD_W-1:0] p);
    logic [DEG_W-1:0] d;
    d = '0;
    for (int i = 0; i < MOD_W; i++) begin
      if (p[i]) begin
        d = DEG_W'(i);
      end
    end
    return d;
  endfunction

endpackage

// ----- design/gfau_dp.sv -----
// ----------------------------------------------------------------------------
// gfau_dp
// Datapath: modulus register, square-and-multiply registers, Euclid
// remainder and coefficient registers, and the result register.
// ----------------------------------------------------------------------------
module gfau_dp import gfau_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [MOD_W-1:0] cfg_wdata_i,
  input  req_t            req_i,
  input  dp_cmd_t         cmd_i,
  output dp_sts_t         sts_o,
  output rsp_t            rsp_o
);

  logic [MOD_W-1:0]      mod_q;
  logic [MOD_W-1:0]      m_eff;
  logic [FIELD_BITS-1:0] res_q, res_d;
  logic [FIELD_BITS-1:0] base_q, base_d;
  logic [EXP_BITS-1:0]   exp_q, exp_d;
  logic [MOD_W-1:0]      rh_q, rh_d, rl_q, rl_d;
  logic [MOD_W-1:0]      th_q, th_d, tl_q, tl_d;
  logic                  azero_q, azero_d;
  rsp_t                  out_q, out_d;
  logic [DEG_W-1:0]      deg_h, deg_l, sh;
  logic                  do_reduce;
  logic [MOD_W-1:0]      inv_full;

  assign m_eff = {1'b1, mod_q[FIELD_BITS-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MODULUS_RESET;
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    deg_h     = poly_deg(rh_q);
    deg_l     = poly_deg(rl_q);
    sh        = deg_h - deg_l;
    do_reduce = (rh_q != '0) && (deg_h >= deg_l);
    inv_full  = th_q[FIELD_BITS] ? (th_q ^ m_eff) : th_q;

    res_d   = res_q;
    base_d  = base_q;
    exp_d   = exp_q;
    rh_d    = rh_q;
    rl_d    = rl_q;
    th_d    = th_q;
    tl_d    = tl_q;
    azero_d = azero_q;
    out_d   = out_q;

    if (cmd_i.load) begin
      unique case (req_i.req_type)
        OP_ADD:  res_d = req_i.operand_a ^ req_i.operand_b;
        OP_MUL:  res_d = gf_mul(req_i.operand_a, req_i.operand_b, m_eff);
        default: res_d = FIELD_BITS'(1);
      endcase
      base_d  = req_i.operand_a;
      exp_d   = req_i.exponent;
      rh_d    = m_eff;
      rl_d    = {1'b0, req_i.operand_a};
      th_d    = '0;
      tl_d    = MOD_W'(1);
      azero_d = (req_i.operand_a == '0);
    end

    if (cmd_i.pow_step) begin
      if (exp_q[0]) begin
        res_d = gf_mul(res_q, base_q, m_eff);
      end
      base_d = gf_mul(base_q, base_q, m_eff);
      exp_d  = exp_q >> 1;
    end

    if (cmd_i.inv_step) begin
      if (do_reduce) begin
        rh_d = rh_q ^ (rl_q << sh);
        th_d = th_q ^ (tl_q << sh);
      end else begin
        rh_d = rl_q;
        rl_d = rh_q;
        th_d = tl_q;
        tl_d = th_q;
      end
    end

    if (cmd_i.finish) begin
      if (cmd_i.finish_inv) begin
        out_d.result             = inv_full[FIELD_BITS-1:0];
        out_d.zero_inverse_error = azero_q;
      end else begin
        out_d.result             = res_q;
        out_d.zero_inverse_error = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    base_q  <= base_d;
    exp_q   <= exp_d;
    rh_q    <= rh_d;
    rl_q    <= rl_d;
    th_q    <= th_d;
    tl_q    <= tl_d;
    azero_q <= azero_d;
    out_q   <= out_d;
  end

  assign sts_o.inv_done = (rl_q == '0);
  assign rsp_o          = out_q;

endmodule

// ----- design/gfau_ctrl.sv -----
// ----------------------------------------------------------------------------
// gfau_ctrl
// Controller: request handshake, operation sequencing, exponent bit
// counter and the response valid flag.
// ----------------------------------------------------------------------------
module gfau_ctrl import gfau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_stall_o,
  input  logic [1:0] req_type_i,
  output logic       rsp_valid_o,
  input  logic       rsp_stall_i,
  output dp_cmd_t    cmd_o,
  input  dp_sts_t    sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POW,
    ST_INV,
    ST_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             inv_q;
  logic             out_valid_q;
  logic             accept;
  logic             slot_free;

  always_comb begin
    req_stall_o      = (state_q != ST_IDLE);
    accept           = req_valid_i && !req_stall_o;
    slot_free        = !out_valid_q || !rsp_stall_i;
    cmd_o.load       = accept;
    cmd_o.pow_step   = (state_q == ST_POW);
    cmd_o.inv_step   = (state_q == ST_INV) && !sts_i.inv_done;
    cmd_o.finish     = (state_q == ST_FIN) && slot_free;
    cmd_o.finish_inv = inv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_o.finish || (out_valid_q && rsp_stall_i);
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            inv_q <= (req_type_i == OP_INV);
            priority if (req_type_i == OP_POW) begin
              state_q <= ST_POW;
            end else if (req_type_i == OP_INV) begin
              state_q <= ST_INV;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_POW: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(EXP_BITS - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_INV: begin
          if (sts_i.inv_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !(out_valid_q && rsp_stall_i))
    else $error("pending response overwritten");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.pow_step, cmd_o.inv_step, cmd_o.finish}))
    else $error("more than one datapath command");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("request accepted without leaving idle");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POW |-> cnt_q < CNT_W'(EXP_BITS))
    else $error("exponent counter overrun");

endmodule

// ----- design/gf2m_field_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// gf2m_field_arithmetic_unit
// GF(2^8) add, multiply, power and extended Euclid inverse over a
// configurable reduction polynomial.
//
//   channel   dir   handshake               payload
//   request   in    req_valid_i/req_stall_o req_i (req_t)
//   response  out   rsp_valid_o/rsp_stall_i rsp_o (rsp_t)
//   config    in    cfg_we_i                cfg_wdata_i (modulus)
//
// add and multiply: the result goes to the result register on accept, then to the response register
// power: one exponent bit per cycle through two combinational
//   field multipliers
// inverse: one quotient bit or one swap per cycle in the Euclid
//   loop
// a new request is taken while the last response waits; a stalled
//   response holds the unit in its final state until the register frees
// reset sets the modulus to 0x11B and empties the unit
// ----------------------------------------------------------------------------
module gf2m_field_arithmetic_unit import gfau_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [MOD_W-1:0] cfg_wdata_i,
  input  logic             req_valid_i,
  output logic             req_stall_o,
  input  req_t             req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_stall_i,
  output rsp_t             rsp_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  gfau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_type_i  (req_i.req_type),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gfau_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule
